// ----- design/sia_pkg.sv -----
// shared types and constants for the slot id allocator
// command codes, sizes and the request structs passed between the top level and its memories
// no dependencies
`default_nettype none
package sia_pkg;

  localparam int NUM_SLOTS = 64;
  localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int COUNT_W   = $clog2(NUM_SLOTS + 1);

  localparam int IN_DATA_W  = 80;
  localparam int OUT_DATA_W = 80;

  localparam logic [1:0] CMD_ALLOCATE = 2'd0;
  localparam logic [1:0] CMD_FREE     = 2'd1;
  localparam logic [1:0] CMD_ASSIGN   = 2'd2;
  localparam logic [1:0] CMD_LOOKUP   = 2'd3;

  typedef struct packed {
    logic              pop;
    logic              push;
    logic [SLOT_W-1:0] slot;
  } stk_op_t;

  typedef struct packed {
    logic              we;
    logic [SLOT_W-1:0] addr;
    logic [31:0]       ops_ref;
    logic [31:0]       sock_ref;
  } tbl_wr_t;

endpackage
`default_nettype wire

// ----- design/slot_id_allocator_with_handle_table_unit.sv -----
// Slot id allocator with a handle table. The cycle a command word is accepted issues
// the reads of the free stack memory and the handle table memory; once the result
// register is empty or being read, a later cycle does the read-modify-write and loads
// the result register; only then is a new command taken (one result per command).
// A waiting result does not block the next command; the block only holds a finished
// command while the result register is still full. After reset the stack holds every
// slot with the highest on top and all handles are empty; this takes effect at once,
// with no clearing pass. Errors (nothing free, slot out of range, stack full on free,
// empty handle on lookup) return status 1 with the other fields zero.
// depends on sia_pkg, sia_free_stack, sia_handle_tbl
`default_nettype none
module slot_id_allocator_with_handle_table_unit
  import sia_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // command[1:0], slot[9:2], sock_ref[41:10], ops_ref[73:42], zero[79:74]
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // status[0], slot_out[8:1], sock_ref_out[40:9], ops_ref_out[72:41], zero[79:73]
  output logic      [OUT_DATA_W-1:0] out_tdata
);

  logic [1:0]   in_command;
  logic [7:0]   in_slot;
  logic [31:0]  in_sock_ref;
  logic [31:0]  in_ops_ref;
  logic         in_accept;

  logic         busy_r;
  logic [1:0]   cmd_r;
  logic [SLOT_W-1:0] slot_r;
  logic [31:0]  sock_r;
  logic [31:0]  ops_r;
  logic         range_ok_r;

  logic         out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic [OUT_DATA_W-1:0] result;
  logic         exec;

  stk_op_t      stk_op;
  tbl_wr_t      tbl_wr;
  logic [COUNT_W-1:0] count;
  logic [SLOT_W-1:0]  top_slot;
  logic [31:0]  rd_sock;
  logic [31:0]  rd_ops;

  logic         status;
  logic [7:0]   slot_out;
  logic [31:0]  sock_out;
  logic [31:0]  ops_out;

  assign in_command  = in_tdata[1:0];
  assign in_slot     = in_tdata[9:2];
  assign in_sock_ref = in_tdata[41:10];
  assign in_ops_ref  = in_tdata[73:42];

  assign in_tready = !busy_r;
  assign in_accept = in_tvalid && in_tready;
  assign exec      = busy_r && (!out_valid_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (in_accept) begin
      busy_r <= 1'b1;
    end else if (exec) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      cmd_r      <= in_command;
      slot_r     <= in_slot[SLOT_W-1:0];
      sock_r     <= in_sock_ref;
      ops_r      <= in_ops_ref;
      range_ok_r <= ({1'b0, in_slot} < 9'(NUM_SLOTS));
    end
  end

  sia_free_stack u_stack (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (in_accept),
    .op       (stk_op),
    .count    (count),
    .top_slot (top_slot)
  );

  sia_handle_tbl u_tbl (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (in_accept),
    .rd_addr  (in_slot[SLOT_W-1:0]),
    .wr       (tbl_wr),
    .sock_ref (rd_sock),
    .ops_ref  (rd_ops)
  );

  always_comb begin
    status          = 1'b0;
    slot_out        = 8'd0;
    sock_out        = 32'd0;
    ops_out         = 32'd0;
    stk_op.pop      = 1'b0;
    stk_op.push     = 1'b0;
    stk_op.slot     = slot_r;
    tbl_wr.we       = 1'b0;
    tbl_wr.addr     = slot_r;
    tbl_wr.sock_ref = sock_r;
    tbl_wr.ops_ref  = ops_r;
    unique case (cmd_r)
      CMD_ALLOCATE: begin
        if (count == COUNT_W'(0)) begin
          status = 1'b1;
        end else begin
          slot_out   = 8'(top_slot);
          stk_op.pop = exec;
        end
      end
      CMD_FREE: begin
        if (!range_ok_r || count >= COUNT_W'(NUM_SLOTS)) begin
          status = 1'b1;
        end else begin
          stk_op.push     = exec;
          tbl_wr.we       = exec;
          tbl_wr.sock_ref = 32'd0;
          tbl_wr.ops_ref  = 32'd0;
        end
      end
      CMD_ASSIGN: begin
        if (!range_ok_r) begin
          status = 1'b1;
        end else begin
          tbl_wr.we = exec;
        end
      end
      CMD_LOOKUP: begin
        if (!range_ok_r || rd_sock == 32'd0 || rd_ops == 32'd0) begin
          status = 1'b1;
        end else begin
          sock_out = rd_sock;
          ops_out  = rd_ops;
        end
      end
      default: begin
        status = 1'b1;
      end
    endcase
  end

  assign result = {7'd0, ops_out, sock_out, slot_out, status};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (exec) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      out_data_r <= result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
`default_nettype wire

// ----- design/sia_free_stack.sv -----
// lifo stack of free slot numbers held in a synchronous memory, plus the fill count
// entries never written since reset read back as their own index
// depends on sia_pkg
`default_nettype none
module sia_free_stack
  import sia_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               rd_en,
  input  wire stk_op_t            op,
  output logic      [COUNT_W-1:0] count,
  output logic      [SLOT_W-1:0]  top_slot
);

  logic [SLOT_W-1:0]  mem [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] vld_r;
  logic [COUNT_W-1:0] count_r;
  logic [COUNT_W-1:0] count_nxt;
  logic [SLOT_W-1:0]  top_idx;
  logic [SLOT_W-1:0]  rdata_r;
  logic [SLOT_W-1:0]  raddr_r;
  logic               rvld_r;

  assign top_idx = count_r[SLOT_W-1:0] - SLOT_W'(1);

  always_comb begin
    count_nxt = count_r;
    if (op.pop) begin
      count_nxt = count_r - COUNT_W'(1);
    end else if (op.push) begin
      count_nxt = count_r + COUNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= COUNT_W'(NUM_SLOTS);
      vld_r   <= '0;
    end else begin
      count_r <= count_nxt;
      if (op.push) begin
        vld_r[count_r[SLOT_W-1:0]] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (op.push) begin
      mem[count_r[SLOT_W-1:0]] <= op.slot;
    end
    if (rd_en) begin
      rdata_r <= mem[top_idx];
      raddr_r <= top_idx;
      rvld_r  <= vld_r[top_idx];
    end
  end

  assign count    = count_r;
  assign top_slot = rvld_r ? rdata_r : raddr_r;

endmodule
`default_nettype wire

// ----- design/sia_handle_tbl.sv -----
// per-slot handle table of two reference words in a synchronous memory
// entries never written since reset read as zero through a valid bit per entry
// depends on sia_pkg
`default_nettype none
module sia_handle_tbl
  import sia_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              rd_en,
  input  wire logic [SLOT_W-1:0] rd_addr,
  input  wire tbl_wr_t           wr,
  output logic      [31:0]       sock_ref,
  output logic      [31:0]       ops_ref
);

  logic [63:0]          mem [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] vld_r;
  logic [63:0]          rdata_r;
  logic                 rvld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr.we) begin
      vld_r[wr.addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= {wr.ops_ref, wr.sock_ref};
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
      rvld_r  <= vld_r[rd_addr];
    end
  end

  assign sock_ref = rvld_r ? rdata_r[31:0]  : 32'd0;
  assign ops_ref  = rvld_r ? rdata_r[63:32] : 32'd0;

endmodule
`default_nettype wire

// ----- design/sia_checker.sv -----
// port-level checks for the slot id allocator, attached to the top level by bind
// depends on sia_pkg and slot_id_allocator_with_handle_table_unit
`default_nettype none
module sia_checker
  import sia_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  in_tvalid,
  input wire logic                  in_tready,
  input wire logic                  out_tvalid,
  input wire logic                  out_tready,
  input wire logic [OUT_DATA_W-1:0] out_tdata
);

  // one command in flight: the cycle after an accepted word takes nothing new
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input taken while a command is in flight");

  // a result never appears without a command accepted before it
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(!in_tready))
    else $error("result without a command in flight");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("stalled result word changed");

  // an error result carries no slot and no handle words
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[0]) |-> (out_tdata[72:1] == 72'd0))
    else $error("error result with nonzero fields");

  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[79:73] == 7'd0))
    else $error("nonzero padding in result word");

endmodule

bind slot_id_allocator_with_handle_table_unit sia_checker u_sia_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
`default_nettype wire

// ----- sim/tb_slot_id_allocator_with_handle_table_unit.sv -----
// testbench for slot_id_allocator_with_handle_table_unit: directed table then random commands,
// every result word checked against a typed expected word or a free stack and handle table
// predictor kept here; depends on sia_pkg and the slot id allocator rtl
`timescale 1ns / 100ps
module tb_slot_id_allocator_with_handle_table_unit;
  import sia_pkg::*;

  typedef struct packed {
    logic        status;
    logic [7:0]  slot;
    logic [31:0] sock;
    logic [31:0] ops;
  } result_t;

  typedef struct {
    logic [1:0]  cmd;
    logic [7:0]  slot;
    logic [31:0] sock;
    logic [31:0] ops;
    bit          typed;
    result_t     res;
  } dir_row_t;

  localparam int N_DIR = 25;
  localparam int N_RAND_PER_PHASE = 620;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;

  // predictor state
  logic [7:0]  pred_stack [NUM_SLOTS];
  int          free_depth;
  logic [31:0] sock_tbl [NUM_SLOTS];
  logic [31:0] ops_tbl [NUM_SLOTS];

  result_t     pending_results [$];
  logic [7:0]  held_slots [$];
  int          fails;
  int          send_idle_pct;
  int          recv_idle_pct;
  result_t     got;
  result_t     want;

  // rows marked typed carry an expected word read off directly, the rest use the predictor
  dir_row_t dir_rows [N_DIR] = '{
    '{CMD_LOOKUP,   8'd0,   32'h0,        32'h0,        1'b1, '{1'b1, 8'd0,  32'h0, 32'h0}},
    '{CMD_ALLOCATE, 8'hff,  32'hffffffff, 32'hffffffff, 1'b1, '{1'b0, 8'd63, 32'h0, 32'h0}},
    '{CMD_ASSIGN,   8'd63,  32'hffffffff, 32'hffffffff, 1'b1, '{1'b0, 8'd0,  32'h0, 32'h0}},
    '{CMD_LOOKUP,   8'd63,  32'h0,        32'h0,        1'b1,
      '{1'b0, 8'd0, 32'hffffffff, 32'hffffffff}},
    '{CMD_FREE,     8'd63,  32'h0,        32'h0,        1'b1, '{1'b0, 8'd0,  32'h0, 32'h0}},
    '{CMD_LOOKUP,   8'd63,  32'h0,        32'h0,        1'b1, '{1'b1, 8'd0,  32'h0, 32'h0}},
    '{CMD_FREE,     8'd63,  32'h0,        32'h0,        1'b1, '{1'b1, 8'd0,  32'h0, 32'h0}},
    '{CMD_FREE,     8'd255, 32'h0,        32'h0,        1'b1, '{1'b1, 8'd0,  32'h0, 32'h0}},
    '{CMD_ASSIGN,   8'd255, 32'ha5a5a5a5, 32'h5a5a5a5a, 1'b1, '{1'b1, 8'd0,  32'h0, 32'h0}},
    '{CMD_LOOKUP,   8'd64,  32'h0,        32'h0,        1'b1, '{1'b1, 8'd0,  32'h0, 32'h0}},
    '{CMD_ALLOCATE, 8'd0,   32'h0,        32'h0,        1'b1, '{1'b0, 8'd63, 32'h0, 32'h0}},
    '{CMD_ALLOCATE, 8'd0,   32'h0,        32'h0,        1'b1, '{1'b0, 8'd62, 32'h0, 32'h0}},
    '{CMD_FREE,     8'd200, 32'h0,        32'h0,        1'b1, '{1'b1, 8'd0,  32'h0, 32'h0}},
    '{CMD_ASSIGN,   8'd62,  32'h1,        32'h1,        1'b1, '{1'b0, 8'd0,  32'h0, 32'h0}},
    '{CMD_FREE,     8'd62,  32'h0,        32'h0,        1'b1, '{1'b0, 8'd0,  32'h0, 32'h0}},
    '{CMD_FREE,     8'd62,  32'h0,        32'h0,        1'b1, '{1'b0, 8'd0,  32'h0, 32'h0}},
    '{CMD_ALLOCATE, 8'd17,  32'h12345678, 32'h9abcdef0, 1'b1, '{1'b0, 8'd62, 32'h0, 32'h0}},
    '{CMD_ASSIGN,   8'd0,   32'h0,        32'h12345678, 1'b1, '{1'b0, 8'd0,  32'h0, 32'h0}},
    '{CMD_LOOKUP,   8'd0,   32'h0,        32'h0,        1'b1, '{1'b1, 8'd0,  32'h0, 32'h0}},
    '{CMD_ASSIGN,   8'd0,   32'h80000000, 32'h0,        1'b1, '{1'b0, 8'd0,  32'h0, 32'h0}},
    '{CMD_LOOKUP,   8'd0,   32'h0,        32'h0,        1'b1, '{1'b1, 8'd0,  32'h0, 32'h0}},
    '{CMD_ASSIGN,   8'd1,   32'h80000000, 32'h1,        1'b1, '{1'b0, 8'd0,  32'h0, 32'h0}},
    '{CMD_LOOKUP,   8'd1,   32'h0,        32'h0,        1'b1,
      '{1'b0, 8'd0, 32'h80000000, 32'h1}},
    '{CMD_ASSIGN,   8'd7,   32'hdeadbeef, 32'h0badf00d, 1'b0, '0},
    '{CMD_ALLOCATE, 8'd0,   32'h0,        32'h0,        1'b0, '0}
  };

  slot_id_allocator_with_handle_table_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("slot_id_allocator_with_handle_table_unit verification failed");
    $finish;
  end

  function automatic result_t apply_slot_cmd(input logic [1:0] cmd, input logic [7:0] slot,
                                             input logic [31:0] sk, input logic [31:0] op);
    result_t r;
    bit      in_range;
    r = '0;
    in_range = slot < NUM_SLOTS;
    case (cmd)
      CMD_ALLOCATE: begin
        if (free_depth == 0) begin
          r.status = 1'b1;
        end else begin
          free_depth--;
          r.slot = pred_stack[free_depth];
        end
      end
      CMD_FREE: begin
        // a repeated free is taken as long as the stack has room
        if (!in_range || free_depth >= NUM_SLOTS) begin
          r.status = 1'b1;
        end else begin
          sock_tbl[slot] = '0;
          ops_tbl[slot] = '0;
          pred_stack[free_depth] = slot;
          free_depth++;
        end
      end
      CMD_ASSIGN: begin
        if (!in_range) begin
          r.status = 1'b1;
        end else begin
          sock_tbl[slot] = sk;
          ops_tbl[slot] = op;
        end
      end
      default: begin
        if (!in_range || sock_tbl[slot] == '0 || ops_tbl[slot] == '0) begin
          r.status = 1'b1;
        end else begin
          r.sock = sock_tbl[slot];
          r.ops = ops_tbl[slot];
        end
      end
    endcase
    return r;
  endfunction

  // mostly slots currently handed out, some arbitrary in range, a few out of range
  function automatic logic [7:0] pick_slot();
    int r;
    r = $urandom_range(99);
    if (r < 70 && held_slots.size() > 0) return held_slots[$urandom_range(held_slots.size() - 1)];
    if (r < 90) return 8'($urandom_range(NUM_SLOTS - 1));
    return 8'($urandom_range(255, NUM_SLOTS));
  endfunction

  function automatic logic [31:0] pick_word();
    int r;
    r = $urandom_range(99);
    if (r < 10) return 32'h0;
    if (r < 15) return 32'hffffffff;
    return $urandom;
  endfunction

  task automatic send_cmd(input logic [1:0] cmd, input logic [7:0] slot, input logic [31:0] sk,
                          input logic [31:0] op, input bit typed, input result_t typed_res);
    result_t pred;
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {6'b0, op, sk, slot, cmd};
    do @(posedge clk); while (!in_tready);
    pred = apply_slot_cmd(cmd, slot, sk, op);
    pending_results.push_back(typed ? typed_res : pred);
    if (cmd == CMD_ALLOCATE && !pred.status) begin
      held_slots.push_back(pred.slot);
    end else if (cmd == CMD_FREE && !pred.status) begin
      for (int i = 0; i < held_slots.size(); i++) begin
        if (held_slots[i] == slot) begin
          held_slots.delete(i);
          break;
        end
      end
    end
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_v, input logic [31:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      fails++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got = '{out_tdata[0], out_tdata[8:1], out_tdata[40:9], out_tdata[72:41]};
      if (pending_results.size() == 0) begin
        $error("result word with nothing expected: %h", out_tdata);
        fails++;
      end else begin
        want = pending_results.pop_front();
        check_field("status", 32'(want.status), 32'(got.status));
        check_field("slot_out", 32'(want.slot), 32'(got.slot));
        check_field("sock_ref_out", want.sock, got.sock);
        check_field("ops_ref_out", want.ops, got.ops);
      end
    end
    out_tready <= (recv_idle_pct == 0) || ($urandom_range(99) >= recv_idle_pct);
  end

  initial begin
    logic [1:0] cmd;
    int         r;
    bit         fill_bias;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    fails = 0;
    send_idle_pct = 19;
    recv_idle_pct = 47;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      pred_stack[i] = 8'(i);
      sock_tbl[i] = '0;
      ops_tbl[i] = '0;
    end
    free_depth = NUM_SLOTS;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      send_cmd(dir_rows[i].cmd, dir_rows[i].slot, dir_rows[i].sock, dir_rows[i].ops,
               dir_rows[i].typed, dir_rows[i].res);
    end
    // empty the stack, then allocate past the end
    for (int i = 0; i < NUM_SLOTS + 2; i++) begin
      send_cmd(CMD_ALLOCATE, 8'($urandom), $urandom, $urandom, 1'b0, '0);
    end
    drain_results();

    fill_bias = 1'b0;
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 19 : (phase == 1) ? 47 : 0;
      recv_idle_pct = (phase == 0) ? 47 : (phase == 1) ? 19 : 0;
      for (int n = 0; n < N_RAND_PER_PHASE; n++) begin
        // swing between filling and emptying so both stack ends are reached
        if (n % 100 == 0) fill_bias = ~fill_bias;
        r = $urandom_range(99);
        if (r < (fill_bias ? 45 : 15)) cmd = CMD_ALLOCATE;
        else if (r < 60) cmd = CMD_FREE;
        else if (r < 80) cmd = CMD_ASSIGN;
        else cmd = CMD_LOOKUP;
        send_cmd(cmd, pick_slot(), pick_word(), pick_word(), 1'b0, '0);
      end
      drain_results();
    end

    repeat (8) @(posedge clk);
    if (fails == 0 && pending_results.size() == 0) begin
      $display("slot_id_allocator_with_handle_table_unit verification clean");
    end else begin
      $display("slot_id_allocator_with_handle_table_unit verification failed");
    end
    $finish;
  end

endmodule
